[rtl/core/psq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package psq_pkg;

  localparam int PRIO_W   = 8;
  localparam int HANDLE_W = 16;
  localparam int STATUS_W = 2;

  typedef enum logic {
    MODE_PUSH = 1'b0,
    MODE_POP  = 1'b1
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_PUSHED    = 2'd0,
    ST_POPPED    = 2'd1,
    ST_POP_EMPTY = 2'd2,
    ST_PUSH_FULL = 2'd3
  } status_t;

  typedef enum logic {
    FSM_IDLE   = 1'b0,
    FSM_RESULT = 1'b1
  } fsm_state_t;

  // controller -> datapath
  typedef struct packed {
    logic do_push;
    logic do_pop;
    logic capture;
  } psq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic empty;
  } psq_stat_t;

endpackage

`default_nettype wire

[rtl/core/priority_stack_queue_unit.sv]
// Output: a transaction's result is strobed on out_valid in the cycle after acceptance.
// Throughput: one push or pop per cycle; every slot compares and shifts in parallel,
//   so the parallel update of the slot array sets the rate and busy stays low.
// Reset: synchronous, active low; empties the queue (fill count to zero) and drops
//   any pending result. Slot contents are not cleared. The receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module priority_stack_queue_unit import psq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // command side: accepted when start is high and busy is low
  input  wire logic                start,
  output logic                     busy,
  input  wire logic                in_mode,
  input  wire logic [PRIO_W-1:0]   in_priority_req,
  input  wire logic [HANDLE_W-1:0] in_handle,
  // result side: one-cycle strobe, no back pressure
  output logic                     out_valid,
  output logic [STATUS_W-1:0]      out_status,
  output logic [PRIO_W-1:0]        out_priority,
  output logic [HANDLE_W-1:0]      out_handle
);

  // Controller picks push/pop/reject from mode and the full/empty status;
  // the datapath is a sorted row of slots, head at slot 0. On a push each
  // slot compares its entry against the new priority: strictly more urgent
  // entries hold, the first slot that is not takes the new entry, and the
  // rest shift down one. Ties land ahead of older entries (newest first).
  // On a pop all slots shift up and the head goes to the result register.

  psq_cmd_t  cmd;
  psq_stat_t stat;

  psq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_mode    (in_mode),
    .stat       (stat),
    .cmd        (cmd),
    .busy       (busy),
    .out_valid  (out_valid),
    .out_status (out_status)
  );

  psq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_priority_req (in_priority_req),
    .in_handle       (in_handle),
    .stat            (stat),
    .out_priority    (out_priority),
    .out_handle      (out_handle)
  );

endmodule

`default_nettype wire

[rtl/core/psq_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module psq_ctrl import psq_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic                in_mode,
  input  wire psq_stat_t           stat,
  output psq_cmd_t                 cmd,
  output logic                     busy,
  output logic                     out_valid,
  output logic [STATUS_W-1:0]      out_status
);

  fsm_state_t state_r, state_nxt;
  status_t    status_r, status_nxt;
  logic       accept;

  // one transaction per cycle; the result register frees the slot array
  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FSM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    status_nxt  = status_r;
    cmd         = '0;
    cmd.capture = accept;
    unique case (state_r)
      FSM_IDLE, FSM_RESULT: begin
        state_nxt = accept ? FSM_RESULT : FSM_IDLE;
      end
      default: state_nxt = FSM_IDLE;
    endcase
    if (accept) begin
      if (mode_t'(in_mode) == MODE_PUSH) begin
        if (stat.full) begin
          status_nxt = ST_PUSH_FULL;
        end else begin
          status_nxt  = ST_PUSHED;
          cmd.do_push = 1'b1;
        end
      end else begin
        if (stat.empty) begin
          status_nxt = ST_POP_EMPTY;
        end else begin
          status_nxt = ST_POPPED;
          cmd.do_pop = 1'b1;
        end
      end
    end
  end

  assign out_valid  = (state_r == FSM_RESULT);
  assign out_status = status_r;

endmodule

`default_nettype wire

[rtl/core/psq_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module psq_datapath import psq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire psq_cmd_t            cmd,
  input  wire logic [PRIO_W-1:0]   in_priority_req,
  input  wire logic [HANDLE_W-1:0] in_handle,
  output psq_stat_t                stat,
  output logic [PRIO_W-1:0]        out_priority,
  output logic [HANDLE_W-1:0]      out_handle
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [PRIO_W-1:0]   prio_r   [DEPTH];
  logic [HANDLE_W-1:0] handle_r [DEPTH];
  logic [DEPTH-1:0]    ahead;  // slot holds a strictly more urgent entry
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [PRIO_W-1:0]   oprio_r;
  logic [HANDLE_W-1:0] ohandle_r;

  assign stat.full  = (count_r == CNT_W'(DEPTH));
  assign stat.empty = (count_r == '0);

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_slot
      logic take_new;
      logic [PRIO_W-1:0]   up_prio, dn_prio;
      logic [HANDLE_W-1:0] up_handle, dn_handle;

      assign ahead[i] = (CNT_W'(i) < count_r) && (prio_r[i] < in_priority_req);

      if (i == 0) begin : g_first
        assign take_new  = !ahead[i];
        assign up_prio   = in_priority_req;
        assign up_handle = in_handle;
      end else begin : g_rest
        assign take_new  = !ahead[i] && ahead[i-1];
        assign up_prio   = prio_r[i-1];
        assign up_handle = handle_r[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
        assign dn_prio   = prio_r[i];
        assign dn_handle = handle_r[i];
      end else begin : g_mid
        assign dn_prio   = prio_r[i+1];
        assign dn_handle = handle_r[i+1];
      end

      always_ff @(posedge clk) begin
        if (cmd.do_push && !ahead[i]) begin
          // insertion point takes the new entry, everything behind moves down
          prio_r[i]   <= take_new ? in_priority_req : up_prio;
          handle_r[i] <= take_new ? in_handle : up_handle;
        end else if (cmd.do_pop) begin
          prio_r[i]   <= dn_prio;
          handle_r[i] <= dn_handle;
        end
      end
    end
  endgenerate

  always_comb begin
    count_nxt = count_r;
    if (cmd.do_push) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      oprio_r   <= cmd.do_pop ? prio_r[0] : '0;
      ohandle_r <= cmd.do_pop ? handle_r[0] : '0;
    end
  end

  assign out_priority = oprio_r;
  assign out_handle   = ohandle_r;

endmodule

`default_nettype wire
